// ----- design/gmgc_pkg.sv -----
// shared constants, gesture codes and the decision tree of the gesture classifier
`timescale 1ns / 1ps

package gmgc_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int NUM_AXES        = 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int GESTURE_W       = 2;
  localparam int SAMPLES_W       = 13;
  localparam int OUT_DATA_W      = 16;
  localparam int FLAGS_W         = 2;

  localparam logic signed [SAMPLE_BITS-1:0] TH_Z_UP    = SAMPLE_BITS'(-8510);
  localparam logic signed [SAMPLE_BITS-1:0] TH_Y_SPLIT = SAMPLE_BITS'(-10814);
  localparam logic signed [SAMPLE_BITS-1:0] TH_X_LOWY  = SAMPLE_BITS'(-236);
  localparam logic signed [SAMPLE_BITS-1:0] TH_X_HIGHY = SAMPLE_BITS'(-226);
  localparam logic signed [SAMPLE_BITS-1:0] TH_Y_RIGHT = SAMPLE_BITS'(-6421);

  typedef enum logic [GESTURE_W-1:0] {
    GEST_UP    = 2'd0,
    GEST_LEFT  = 2'd1,
    GEST_RIGHT = 2'd2,
    GEST_DOWN  = 2'd3
  } gesture_e;

  function automatic gesture_e classify(input logic signed [SAMPLE_BITS-1:0] mx,
                                        input logic signed [SAMPLE_BITS-1:0] my,
                                        input logic signed [SAMPLE_BITS-1:0] mz);
    gesture_e g;
    if (mz <= TH_Z_UP) begin
      g = GEST_UP;
    end else if (my <= TH_Y_SPLIT) begin
      g = (mx <= TH_X_LOWY) ? GEST_LEFT : GEST_UP;
    end else if (mx <= TH_X_HIGHY) begin
      g = GEST_LEFT;
    end else begin
      g = (my <= TH_Y_RIGHT) ? GEST_RIGHT : GEST_DOWN;
    end
    return g;
  endfunction

endpackage

// ----- design/gmgc_front.sv -----
// front end: button edge detection, per-axis accumulation and job hand-off on release
`timescale 1ns / 1ps

module gmgc_front #(
  parameter int  MAX_SAMPLES = gmgc_pkg::MAX_SAMPLES_DEF,
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W       = gmgc_pkg::SAMPLE_BITS + CNT_W,
  localparam int JOB_W       = gmgc_pkg::NUM_AXES * SUM_W + CNT_W
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              s_valid_i,
  output logic                                              s_ready_o,
  // button_level, sample_ok
  input  logic [gmgc_pkg::FLAGS_W-1:0]                      s_user_i,
  // accel_x, accel_y, accel_z
  input  logic [gmgc_pkg::NUM_AXES*gmgc_pkg::SAMPLE_BITS-1:0] s_data_i,
  output logic                                              job_valid_o,
  input  logic                                              job_ready_i,
  output logic [JOB_W-1:0]                                  job_data_o
);
  import gmgc_pkg::*;

  logic                    cap_q, last_q;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_base;
  logic signed [SUM_W-1:0] sum_q [NUM_AXES];
  logic signed [SUM_W-1:0] sum_d [NUM_AXES];
  logic                    accept, btn, ok, rise, fall, cap_next, add;

  assign s_ready_o = job_ready_i;
  assign accept    = s_valid_i & job_ready_i;
  assign btn       = s_user_i[0];
  assign ok        = s_user_i[1];
  assign rise      = btn & ~last_q;
  assign fall      = ~btn & last_q & cap_q;
  assign cap_next  = rise | (cap_q & ~fall);
  assign cnt_base  = rise ? '0 : cnt_q;
  assign add       = cap_next & btn & ok & (cnt_base < CNT_W'(MAX_SAMPLES));
  assign cnt_d     = add ? cnt_base + CNT_W'(1) : cnt_base;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_d[a] = (rise ? '0 : sum_q[a]) +
                 (add ? SUM_W'($signed(s_data_i[a*SAMPLE_BITS +: SAMPLE_BITS])) : '0);
    end
  end

  assign job_valid_o = accept & fall & (cnt_q != '0);
  assign job_data_o  = {sum_q[2], sum_q[1], sum_q[0], cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= 1'b0;
      last_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      cap_q  <= cap_next;
      last_q <= btn;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sum_q[a] <= sum_d[a];
      end
    end
  end

endmodule

// ----- design/gmgc_queue.sv -----
// short job queue between the front end and the divider back end
`timescale 1ns / 1ps

module gmgc_queue #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = gmgc_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0]  entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [FILL_W-1:0] fill_q;
  logic              push, pop;

  assign push_ready_o = fill_q != FILL_W'(DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_data_o   = entry_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/gmgc_back.sv -----
// back end: shared bit-serial divider for the three means, decision tree, output register
`timescale 1ns / 1ps

module gmgc_back #(
  parameter int  MAX_SAMPLES = gmgc_pkg::MAX_SAMPLES_DEF,
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W       = gmgc_pkg::SAMPLE_BITS + CNT_W,
  localparam int JOB_W       = gmgc_pkg::NUM_AXES * SUM_W + CNT_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  output logic                            job_ready_o,
  input  logic [JOB_W-1:0]                job_data_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  // gesture, samples_used, zero pad
  output logic [gmgc_pkg::OUT_DATA_W-1:0] m_data_o
);
  import gmgc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);
  localparam int AXIS_W = $clog2(NUM_AXES);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_CLS} state_e;

  state_e                  state_q;
  logic [AXIS_W-1:0]       axis_q;
  logic [STEP_W-1:0]       step_q;
  logic                    m_valid_q;
  logic [OUT_DATA_W-1:0]   out_q;

  logic signed [SUM_W-1:0]       sum_q [NUM_AXES];
  logic [CNT_W-1:0]              cnt_q;
  logic [SUM_W-1:0]              dvd_q;
  logic [CNT_W-1:0]              rem_q;
  logic                          neg_q;
  logic signed [SAMPLE_BITS-1:0] mean_q [NUM_AXES];

  logic signed [SUM_W-1:0]       sum_sel;
  logic [SUM_W-1:0]              abs_sel, quo_d, q_signed;
  logic [CNT_W:0]                rem_sh, den, rem_sub;
  logic [CNT_W-1:0]              rem_d;
  logic                          ge, last_step, out_load, take_job;
  logic [CNT_W+SAMPLES_W-1:0]    cnt_ext;
  gesture_e                      gest;

  assign job_ready_o = state_q == S_IDLE;
  assign take_job    = job_valid_i && (state_q == S_IDLE);

  assign sum_sel  = sum_q[axis_q];
  assign abs_sel  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
  assign den      = {1'b0, cnt_q};
  assign ge       = rem_sh >= den;
  assign rem_sub  = rem_sh - den;
  assign rem_d    = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign quo_d    = {dvd_q[SUM_W-2:0], ge};
  assign q_signed = neg_q ? SUM_W'(-quo_d) : quo_d;

  assign last_step = step_q == STEP_W'(SUM_W - 1);
  assign out_load  = (state_q == S_CLS) && (!m_valid_q || m_ready_i);
  assign cnt_ext   = {{SAMPLES_W{1'b0}}, cnt_q};
  assign gest      = classify(mean_q[0], mean_q[1], mean_q[2]);

  assign m_valid_o = m_valid_q;
  assign m_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      axis_q    <= '0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
      out_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            axis_q  <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (last_step) begin
            if (axis_q == AXIS_W'(NUM_AXES - 1)) begin
              state_q <= S_CLS;
            end else begin
              axis_q  <= axis_q + AXIS_W'(1);
              state_q <= S_LOAD;
            end
          end
        end
        S_CLS: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (out_load) begin
        m_valid_q <= 1'b1;
        out_q     <= {{(OUT_DATA_W - GESTURE_W - SAMPLES_W){1'b0}},
                      cnt_ext[SAMPLES_W-1:0], gest};
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (take_job) begin
          cnt_q <= job_data_i[CNT_W-1:0];
          for (int a = 0; a < NUM_AXES; a++) begin
            sum_q[a] <= job_data_i[CNT_W + a*SUM_W +: SUM_W];
          end
        end
      end
      S_LOAD: begin
        dvd_q <= abs_sel;
        neg_q <= sum_sel[SUM_W-1];
        rem_q <= '0;
      end
      S_DIV: begin
        dvd_q <= quo_d;
        rem_q <= rem_d;
        if (last_step) begin
          mean_q[axis_q] <= q_signed[SAMPLE_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_job |=> state_q == S_LOAD)
    else $error("job taken without starting a division");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < cnt_q)
    else $error("divider remainder not below the count");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> cnt_q != '0)
    else $error("division started with a zero count");

  a_out_from_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_CLS))
    else $error("result shown without finishing classification");

endmodule

// ----- design/gated_accel_mean_gesture_classifier.sv -----
// top level of the gated accelerometer mean gesture classifier
`timescale 1ns / 1ps

// One sensor tick is accepted per cycle whenever the two-entry job queue has room; ticks
// are summed per axis while the button is held. On release a job with the sums and the
// count enters the queue if the count is nonzero, and the back end divides the three axes
// one after the other in a shared restoring divider, one quotient bit per cycle, then runs
// the decision tree and registers the result. The sums are SUM_W bits wide, 16 plus the
// count width, 29 at the default of 4096 samples. With the queue full the front end holds
// tready low until the back end takes the next job.
module gated_accel_mean_gesture_classifier #(
  parameter int MAX_SAMPLES = gmgc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                s_axis_tvalid_i,
  output logic                                                s_axis_tready_o,
  // accel_x, accel_y, accel_z
  input  logic [gmgc_pkg::NUM_AXES*gmgc_pkg::SAMPLE_BITS-1:0] s_axis_tdata_i,
  // button_level, sample_ok
  input  logic [gmgc_pkg::FLAGS_W-1:0]                        s_axis_tuser_i,
  output logic                                                m_axis_tvalid_o,
  input  logic                                                m_axis_tready_i,
  // gesture, samples_used, zero pad
  output logic [gmgc_pkg::OUT_DATA_W-1:0]                     m_axis_tdata_o
);
  import gmgc_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int JOB_W = NUM_AXES * SUM_W + CNT_W;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [JOB_W-1:0] push_data, pop_data;

  gmgc_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_user_i    (s_axis_tuser_i),
    .s_data_i    (s_axis_tdata_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_data_o  (push_data)
  );

  gmgc_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  gmgc_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_data_i  (pop_data),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o)
  );

endmodule
